// ===== design/buddy_block_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// buddy block allocator assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define BBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bba check failed");
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bba check failed");
`else
`define BBA_ASSERT_IMPL(lbl, ante, cons)
`define BBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// constants, codes and shared types of the buddy block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bba_pkg;
  localparam int MAX_ORDER  = 10;
  localparam int LIST_DEPTH = 512;
  localparam int NUM_ORDERS = MAX_ORDER + 1;
  localparam int ADDR_W     = 10;
  localparam int ORDER_W    = 4;
  localparam int KW         = $clog2(MAX_ORDER + 2);
  localparam int CIW        = $clog2(NUM_ORDERS);
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int MEM_DEPTH  = NUM_ORDERS * LIST_DEPTH;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RES_BAD,
    OP_RES_NOSPACE,
    OP_K_INC,
    OP_A_POP,
    OP_A_BASE,
    OP_K_DEC,
    OP_PUSH_SPLIT,
    OP_RES_ALLOC,
    OP_F_START,
    OP_F_RD,
    OP_F_FOUND,
    OP_F_SHRD,
    OP_F_SHWR,
    OP_F_MERGE
  } bba_op_e;

  typedef struct packed {
    logic err_order;
    logic err_align;
    logic k_gt_max;
    logic k_eq_max;
    logic k_gt_ord;
    logic cnt_zero;
    logic i_zero;
    logic j_eq_c;
    logic match;
    logic out_free;
  } bba_stat_t;

  typedef struct packed {
    bba_op_e op;
    logic    push_final;
  } bba_cmd_t;

  function automatic logic [MEM_AW-1:0] mem_addr(logic [KW-1:0] k, logic [IDX_W-1:0] idx);
    mem_addr = MEM_AW'(k) * MEM_AW'(LIST_DEPTH) + MEM_AW'(idx);
  endfunction
endpackage

// ===== design/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba channel interfaces
// request and result channels with valid and ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface bba_req_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [ORDER_W-1:0] order;
  logic [ADDR_W-1:0]  address;
  modport source (output valid, mode, order, address, input ready);
  modport sink (input valid, mode, order, address, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ADDR_W-1:0]  block_address;
  logic [ORDER_W-1:0] block_order;
  modport source (output valid, status, block_address, block_order, input ready);
  modport sink (input valid, status, block_address, block_order, output ready);
endinterface

// ===== design/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer of the allocator: issues at most one datapath command per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bba_ctrl import bba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_mode_i,
  output logic      in_ready_o,
  input  bba_stat_t stat_i,
  output bba_cmd_t  cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_ERR_BAD, S_A_SCAN, S_ERR_NOSPACE, S_A_BASE, S_A_SPLIT, S_A_SPUSH,
    S_F_CHECK, S_F_SRCH, S_F_CMP, S_F_SHIFT, S_F_SHWR, S_F_PUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    cmd_o.push_final = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (stat_i.err_order || (in_mode_i && stat_i.err_align)) state_d = S_ERR_BAD;
          else if (in_mode_i) state_d = S_F_CHECK;
          else state_d = S_A_SCAN;
        end
      end
      S_ERR_BAD: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_RES_BAD;
          state_d = S_IDLE;
        end
      end
      S_A_SCAN: begin
        if (stat_i.k_gt_max) state_d = S_ERR_NOSPACE;
        else if (stat_i.cnt_zero) cmd_o.op = OP_K_INC;
        else begin
          cmd_o.op = OP_A_POP;
          state_d = S_A_BASE;
        end
      end
      S_ERR_NOSPACE: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_RES_NOSPACE;
          state_d = S_IDLE;
        end
      end
      S_A_BASE: begin
        cmd_o.op = OP_A_BASE;
        state_d = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        if (stat_i.k_gt_ord) begin
          cmd_o.op = OP_K_DEC;
          state_d = S_A_SPUSH;
        end else if (stat_i.out_free) begin
          cmd_o.op = OP_RES_ALLOC;
          state_d = S_IDLE;
        end
      end
      S_A_SPUSH: begin
        cmd_o.op = OP_PUSH_SPLIT;
        state_d = S_A_SPLIT;
      end
      S_F_CHECK: begin
        if (stat_i.k_eq_max) state_d = S_F_PUSH;
        else begin
          cmd_o.op = OP_F_START;
          state_d = S_F_SRCH;
        end
      end
      S_F_SRCH: begin
        if (stat_i.i_zero) state_d = S_F_PUSH;
        else begin
          cmd_o.op = OP_F_RD;
          state_d = S_F_CMP;
        end
      end
      S_F_CMP: begin
        if (stat_i.match) begin
          cmd_o.op = OP_F_FOUND;
          state_d = S_F_SHIFT;
        end else state_d = S_F_SRCH;
      end
      S_F_SHIFT: begin
        if (stat_i.j_eq_c) begin
          cmd_o.op = OP_F_MERGE;
          state_d = S_F_CHECK;
        end else begin
          cmd_o.op = OP_F_SHRD;
          state_d = S_F_SHWR;
        end
      end
      S_F_SHWR: begin
        cmd_o.op = OP_F_SHWR;
        state_d = S_F_SHIFT;
      end
      S_F_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push_final = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== design/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// free lists, per-order counts, working registers and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bba_dp import bba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bba_cmd_t           cmd_i,
  output bba_stat_t          stat_o,
  input  logic [ORDER_W-1:0] in_order_i,
  input  logic [ADDR_W-1:0]  in_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_status_o,
  output logic [ADDR_W-1:0]  out_address_o,
  output logic [ORDER_W-1:0] out_order_o
);
  localparam logic [MEM_AW-1:0] TOP0 = MEM_AW'(MAX_ORDER * LIST_DEPTH);

  logic [ADDR_W-1:0] mem [MEM_DEPTH];
  logic [ADDR_W-1:0] mem_q;
  logic              rd_zero_q;
  logic              top0_q;
  logic [CNT_W-1:0]  cnt_q [NUM_ORDERS];

  logic [KW-1:0]      k_q;
  logic [ORDER_W-1:0] ord_q;
  logic [ADDR_W-1:0]  addr_q, base_q;
  logic [CNT_W-1:0]   i_q, j_q;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [ADDR_W-1:0]  out_address_q;
  logic [ORDER_W-1:0] out_order_q;

  logic              k_ok;
  logic [CIW-1:0]    k_idx;
  logic [CNT_W-1:0]  cnt_k;
  logic [ADDR_W-1:0] rdata, k_bit, buddy, merged, align_mask;
  logic              rd_en, wr_en;
  logic [MEM_AW-1:0] rd_addr, wr_addr;
  logic [ADDR_W-1:0] wr_data;
  logic              push, cnt_inc, cnt_dec;
  logic              out_free;

  assign k_ok   = (k_q <= KW'(MAX_ORDER));
  assign k_idx  = k_q[CIW-1:0];
  assign cnt_k  = k_ok ? cnt_q[k_idx] : '0;
  assign rdata  = rd_zero_q ? '0 : mem_q;
  assign k_bit  = ADDR_W'(1) << k_q;
  assign buddy  = addr_q ^ k_bit;
  assign merged = (buddy < addr_q) ? buddy : addr_q;
  assign align_mask = ~({ADDR_W{1'b1}} << in_order_i);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.err_order = (in_order_i > ORDER_W'(MAX_ORDER));
    stat_o.err_align = ((in_address_i & align_mask) != '0);
    stat_o.k_gt_max  = !k_ok;
    stat_o.k_eq_max  = (k_q == KW'(MAX_ORDER));
    stat_o.k_gt_ord  = (k_q > KW'(ord_q));
    stat_o.cnt_zero  = (cnt_k == '0);
    stat_o.i_zero    = (i_q == '0);
    stat_o.j_eq_c    = (j_q == cnt_k);
    stat_o.match     = (rdata == buddy);
    stat_o.out_free  = out_free;
  end

  // memory port selection
  always_comb begin
    push    = (cmd_i.op == OP_PUSH_SPLIT) || cmd_i.push_final;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = mem_addr(k_q, cnt_k[IDX_W-1:0]);
    wr_data = (cmd_i.op == OP_PUSH_SPLIT) ? base_q + k_bit : addr_q;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    case (cmd_i.op)
      OP_A_POP: begin
        rd_en   = 1'b1;
        rd_addr = mem_addr(k_q, IDX_W'(cnt_k - CNT_W'(1)));
        cnt_dec = 1'b1;
      end
      OP_F_RD: begin
        rd_en   = 1'b1;
        rd_addr = mem_addr(k_q, IDX_W'(i_q - CNT_W'(1)));
      end
      OP_F_SHRD: begin
        rd_en   = 1'b1;
        rd_addr = mem_addr(k_q, j_q[IDX_W-1:0]);
      end
      OP_F_SHWR: begin
        wr_en   = 1'b1;
        wr_addr = mem_addr(k_q, IDX_W'(j_q - CNT_W'(1)));
        wr_data = rdata;
      end
      OP_F_MERGE: cnt_dec = 1'b1;
      default: ;
    endcase
    if (push && (cnt_k < CNT_W'(LIST_DEPTH))) begin
      wr_en   = 1'b1;
      cnt_inc = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  // control state: counts, top entry flag, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NUM_ORDERS; n++) begin
        cnt_q[n] <= (n == MAX_ORDER) ? CNT_W'(1) : '0;
      end
      top0_q      <= 1'b0;
      rd_zero_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cnt_inc) cnt_q[k_idx] <= cnt_k + CNT_W'(1);
      else if (cnt_dec) cnt_q[k_idx] <= cnt_k - CNT_W'(1);
      if (wr_en && (wr_addr == TOP0)) top0_q <= 1'b1;
      if (rd_en) rd_zero_q <= (rd_addr == TOP0) && !top0_q;
      if ((cmd_i.op == OP_RES_BAD) || (cmd_i.op == OP_RES_NOSPACE) ||
          (cmd_i.op == OP_RES_ALLOC) || cmd_i.push_final) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op) inside
      OP_LOAD: begin
        k_q    <= KW'(in_order_i);
        ord_q  <= in_order_i;
        addr_q <= in_address_i;
      end
      OP_K_INC:   k_q <= k_q + KW'(1);
      OP_K_DEC:   k_q <= k_q - KW'(1);
      OP_A_BASE:  base_q <= rdata;
      OP_F_START: i_q <= cnt_k;
      OP_F_RD:    i_q <= i_q - CNT_W'(1);
      OP_F_FOUND: j_q <= i_q + CNT_W'(1);
      OP_F_SHWR:  j_q <= j_q + CNT_W'(1);
      OP_F_MERGE: begin
        addr_q <= merged;
        k_q    <= k_q + KW'(1);
      end
      OP_RES_BAD, OP_RES_NOSPACE: begin
        out_status_q  <= (cmd_i.op == OP_RES_BAD) ? ST_BAD : ST_NOSPACE;
        out_address_q <= '0;
        out_order_q   <= '0;
      end
      OP_RES_ALLOC: begin
        out_status_q  <= ST_OK;
        out_address_q <= base_q;
        out_order_q   <= ord_q;
      end
      default: ;
    endcase
    if (cmd_i.push_final) begin
      out_status_q  <= ST_OK;
      out_address_q <= addr_q;
      out_order_q   <= ORDER_W'(k_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_address_o = out_address_q;
  assign out_order_o   = out_order_q;
endmodule

// ===== design/buddy_block_allocator.sv =====
// allocate: load, skip empty orders, pop, take the base, split down to the asked order
// free: per merge level the order's list is searched from its newest entry, and the
// entries above the buddy move down one place, all through the one list memory port
// one transaction in flight; the next is taken once the result sits in the output register
// reset: asynchronous, top order list holds block 0, all other lists empty, no clearing pass
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator with one lifo free list per order, split on allocate, merge on free
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_assert.svh"
module buddy_block_allocator import bba_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  bba_req_if.sink   in_i,
  bba_rsp_if.source out_o
);
  bba_stat_t stat;
  bba_cmd_t  cmd;
  logic      in_ready;

  // sequencer: at most one command a cycle, free list walk and split loop
  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // lists, counts and the result register
  bba_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_order_i    (in_i.order),
    .in_address_i  (in_i.address),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_status_o  (out_o.status),
    .out_address_o (out_o.block_address),
    .out_order_o   (out_o.block_order)
  );

  assign in_i.ready = in_ready;

  // error results carry a zero block
  `BBA_ASSERT_IMPL(a_err_zero, out_o.valid && (out_o.status != ST_OK),
                   (out_o.block_address == '0) && (out_o.block_order == '0))
  // a successful block is aligned to its own size
  `BBA_ASSERT_IMPL(a_aligned, out_o.valid && (out_o.status == ST_OK),
                   ((out_o.block_address >> out_o.block_order) << out_o.block_order)
                   == out_o.block_address)
  // one transaction at a time
  `BBA_ASSERT_NEXT(a_busy, in_i.valid && in_i.ready, !in_i.ready)
endmodule

// ===== sim/buddy_block_allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy block allocator checker
// watches both channels, predicts each result from its own copy of the free
// lists and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module buddy_block_allocator_checker import bba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bba_req_if   req_i,
  bba_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  addr;
    logic [ORDER_W-1:0] ord;
  } block_result_t;

  localparam int EXP_DEPTH = 16;

  logic [ADDR_W-1:0] free_blocks [NUM_ORDERS][LIST_DEPTH];
  int                free_cnt    [NUM_ORDERS];
  block_result_t     expected_results [EXP_DEPTH];
  int                exp_head, exp_tail, exp_count;
  int                fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = exp_count;

  task automatic report(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void push_free(input int k, input logic [ADDR_W-1:0] a);
    if (free_cnt[k] < LIST_DEPTH) begin
      free_blocks[k][free_cnt[k]] = a;
      free_cnt[k]++;
    end
  endfunction

  // newest matching entry goes, the rest keep their order
  function automatic bit take_free(input int k, input logic [ADDR_W-1:0] a);
    for (int i = free_cnt[k] - 1; i >= 0; i--) begin
      if (free_blocks[k][i] == a) begin
        for (int j = i; j < free_cnt[k] - 1; j++) free_blocks[k][j] = free_blocks[k][j+1];
        free_cnt[k]--;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic block_result_t predict_block(input logic m, input int ord,
                                                  input logic [ADDR_W-1:0] a);
    block_result_t r;
    int k;
    logic [ADDR_W-1:0] base, buddy;
    r = '0;
    if (ord > MAX_ORDER) begin
      r.status = ST_BAD;
    end else if (!m) begin
      k = ord;
      while (k <= MAX_ORDER && free_cnt[k] == 0) k++;
      if (k > MAX_ORDER) begin
        r.status = ST_NOSPACE;
      end else begin
        free_cnt[k]--;
        base = free_blocks[k][free_cnt[k]];
        while (k > ord) begin
          k--;
          push_free(k, base + ADDR_W'(1 << k));
        end
        r.status = ST_OK;
        r.addr   = base;
        r.ord    = ORDER_W'(ord);
      end
    end else if ((int'(a) & ((1 << ord) - 1)) != 0) begin
      r.status = ST_BAD;
    end else begin
      k = ord;
      base = a;
      while (k < MAX_ORDER) begin
        buddy = base ^ ADDR_W'(1 << k);
        if (!take_free(k, buddy)) break;
        if (buddy < base) base = buddy;
        k++;
      end
      push_free(k, base);
      r.status = ST_OK;
      r.addr   = base;
      r.ord    = ORDER_W'(k);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    block_result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_ORDERS; k++) free_cnt[k] = 0;
      free_blocks[MAX_ORDER][0] = '0;
      free_cnt[MAX_ORDER] = 1;
      exp_head   = 0;
      exp_tail   = 0;
      exp_count  = 0;
      fail_count = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (exp_count == 0) begin
          $display("%0t: result transaction with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = expected_results[exp_head];
          exp_head = (exp_head + 1) % EXP_DEPTH;
          exp_count--;
          if (rsp_i.status !== want.status) report("status", rsp_i.status, want.status);
          if (rsp_i.block_address !== want.addr)
            report("block_address", rsp_i.block_address, want.addr);
          if (rsp_i.block_order !== want.ord)
            report("block_order", rsp_i.block_order, want.ord);
        end
      end
      if (req_i.valid && req_i.ready) begin
        if (exp_count == EXP_DEPTH) begin
          $display("%0t: too many transactions awaiting a result", $realtime);
          fail_count++;
        end else begin
          expected_results[exp_tail] = predict_block(req_i.mode, req_i.order, req_i.address);
          exp_tail = (exp_tail + 1) % EXP_DEPTH;
          exp_count++;
        end
      end
    end
  end

endmodule

// ===== sim/buddy_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy block allocator testbench
// directed corner requests then a random mix of allocations, frees of held
// blocks and malformed requests, with random gaps and result back-pressure
// ----------------------------------------------------------------------------
module buddy_block_allocator_tb import bba_pkg::*;;

  localparam int  RANDOM_ITEMS = 480;
  localparam int  CYCLE_LIMIT  = 3000000;
  localparam int  HELD_MAX     = 4096;
  localparam bit  REQ_ALLOC    = 1'b0;
  localparam bit  REQ_FREE     = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, cycles;
  int   n_alloc, n_free, n_err;
  bit   stimulus_done = 0;

  // blocks the stimulus currently holds, as returned by the block
  logic [ADDR_W-1:0]  held_addr [HELD_MAX];
  logic [ORDER_W-1:0] held_ord  [HELD_MAX];
  int                 n_held = 0;
  logic [1:0]         last_status;
  logic [ADDR_W-1:0]  last_addr;
  logic [ORDER_W-1:0] last_ord;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  buddy_block_allocator u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  buddy_block_allocator_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // mostly short gaps, now and then a long one, and runs with none
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic void hold_block(input logic [ADDR_W-1:0] a, input logic [ORDER_W-1:0] o);
    if (n_held < HELD_MAX) begin
      held_addr[n_held] = a;
      held_ord[n_held]  = o;
      n_held++;
    end
  endfunction

  function automatic void drop_held(input int idx);
    for (int i = idx; i < n_held - 1; i++) begin
      held_addr[i] = held_addr[i+1];
      held_ord[i]  = held_ord[i+1];
    end
    n_held--;
  endfunction

  // result side back-pressure
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int g;
      g = gap_len();
      if (g > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  end

  // one transaction in flight: send, then wait for its result
  task automatic issue(input logic m, input logic [ORDER_W-1:0] o, input logic [ADDR_W-1:0] a);
    int g;
    g = gap_len();
    repeat (g) @(posedge clk_i);
    req_if.valid   <= 1'b1;
    req_if.mode    <= m;
    req_if.order   <= o;
    req_if.address <= a;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    last_status = rsp_if.status;
    last_addr   = rsp_if.block_address;
    last_ord    = rsp_if.block_order;
    if (last_status != ST_OK) n_err++;
    else if (m == REQ_ALLOC) begin
      n_alloc++;
      hold_block(last_addr, last_ord);
    end else n_free++;
  endtask

  task automatic free_held(input int idx);
    logic [ADDR_W-1:0]  a;
    logic [ORDER_W-1:0] o;
    a = held_addr[idx];
    o = held_ord[idx];
    drop_held(idx);
    issue(REQ_FREE, o, a);
  endtask

  task automatic random_request();
    int p;
    p = $urandom_range(99);
    if (p < 50 || (p < 85 && n_held == 0)) begin
      // small orders mostly, the odd big one
      issue(REQ_ALLOC, ($urandom_range(9) == 0) ? ORDER_W'($urandom_range(MAX_ORDER))
                                                : ORDER_W'($urandom_range(4)), '0);
    end else if (p < 85) begin
      free_held($urandom_range(n_held - 1));
    end else if (p < 90) begin
      issue(1'($urandom_range(1)), ORDER_W'($urandom_range(15, MAX_ORDER + 1)),
            ADDR_W'($urandom));
    end else if (p < 95) begin
      // free of a block not held: misaligned or foreign
      issue(REQ_FREE, ORDER_W'($urandom_range(MAX_ORDER)), ADDR_W'($urandom));
    end else begin
      issue(REQ_ALLOC, ORDER_W'($urandom_range(MAX_ORDER)), ADDR_W'($urandom));
    end
  endtask

  initial begin
    req_if.valid   = 1'b0;
    req_if.mode    = REQ_ALLOC;
    req_if.order   = '0;
    req_if.address = '0;
    n_alloc = 0; n_free = 0; n_err = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // whole space, then nothing left, then give it back
    issue(REQ_ALLOC, ORDER_W'(MAX_ORDER), '1);
    issue(REQ_ALLOC, '0, '0);
    free_held(0);
    // bad orders on both operations
    issue(REQ_ALLOC, ORDER_W'(MAX_ORDER + 1), '0);
    issue(REQ_FREE, '1, '0);
    // smallest block splits the whole space, freeing both merges up to the top
    issue(REQ_ALLOC, '0, '0);
    issue(REQ_ALLOC, '0, '0);
    free_held(0);
    free_held(0);
    // misaligned free and a free of the top address
    issue(REQ_FREE, 4'd3, 10'd4);
    issue(REQ_FREE, 4'd1, 10'h3ff);
    issue(REQ_FREE, '0, 10'h3ff);
    // double free of a held block leaves a duplicate entry behind
    issue(REQ_ALLOC, 4'd2, '0);
    issue(REQ_FREE, held_ord[0], held_addr[0]);
    free_held(0);
    issue(REQ_ALLOC, 4'd9, '0);
    issue(REQ_ALLOC, 4'd9, '0);
    issue(REQ_ALLOC, 4'd9, '0);
    while (n_held > 0) free_held(0);

    for (int n = 0; n < RANDOM_ITEMS; n++) random_request();
    while (n_held > 0) free_held($urandom_range(n_held - 1));

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    stimulus_done = 1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (stimulus_done) begin
      $display("covered %0d good allocations, %0d good frees, %0d refused requests",
               n_alloc, n_free, n_err);
      if (fail_count == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
      $finish;
    end else if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial cycles = 0;

endmodule

// ===== buddy_block_allocator.f =====
+incdir+design
design/bba_pkg.sv
design/bba_if.sv
design/bba_ctrl.sv
design/bba_dp.sv
design/buddy_block_allocator.sv
sim/buddy_block_allocator_checker.sv
sim/buddy_block_allocator_tb.sv
